// File: sv/pnos_pkg.sv
// pnos_pkg: shared constants, codes and structs of the octave-summed perlin noise unit
// depends on nothing; used by every other file of the block
package pnos_pkg;

   localparam int KIND_W     = 2;
   localparam int IDX_W      = 8;
   localparam int PERM_W     = 8;
   localparam int GRAD_W     = 16;
   localparam int GENTRY_W   = 2 * GRAD_W;
   localparam int COORD_W    = 32;
   localparam int NOISE_W    = 25;
   localparam int AMP_W      = 16;
   localparam int FREQ_W     = 16;
   localparam int DEPTH_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TABLE_SIZE = 256;

   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 19;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [KIND_W-1:0] KIND_XPERM = 2'd0;
   localparam logic [KIND_W-1:0] KIND_YPERM = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GRAD  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EVAL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_AMP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH = 2'd2;

   localparam logic [AMP_W-1:0]   AMP_RESET   = 16'd256;
   localparam logic [FREQ_W-1:0]  FREQ_RESET  = 16'd256;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd0;

   localparam logic [NOISE_W-1:0] SAT_MAX = 25'h1FFFFFF;

   typedef struct packed {
      logic [AMP_W-1:0]   amp;
      logic [FREQ_W-1:0]  freq;
      logic [DEPTH_W-1:0] depth;
   } cfg_type;

   typedef struct packed {
      logic                we_x;
      logic                we_y;
      logic                we_g;
      logic [IDX_W-1:0]    index;
      logic [PERM_W-1:0]   perm;
      logic [GENTRY_W-1:0] grad;
   } tbl_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0] x_addr;
      logic [IDX_W-1:0] y_addr;
      logic [IDX_W-1:0] g_addr;
   } tbl_rd_type;

   typedef struct packed {
      logic               ready;
      logic               done;
      logic [NOISE_W-1:0] sum;
   } core_stat_type;

endpackage

// File: sv/pnos_if.sv
// pnos_req_if and pnos_rsp_if: valid/ready channels of the noise unit
// depends on pnos_pkg
interface pnos_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [pnos_pkg::KIND_W-1:0]          kind;
   logic [pnos_pkg::IDX_W-1:0]           table_index;
   logic [pnos_pkg::PERM_W-1:0]          perm_value;
   logic signed [pnos_pkg::GRAD_W-1:0]   grad_x;
   logic signed [pnos_pkg::GRAD_W-1:0]   grad_y;
   logic signed [pnos_pkg::COORD_W-1:0]  coord_x;
   logic signed [pnos_pkg::COORD_W-1:0]  coord_y;

   modport source (output valid, kind, table_index, perm_value, grad_x, grad_y,
                   coord_x, coord_y, input ready);
   modport sink   (input valid, kind, table_index, perm_value, grad_x, grad_y,
                   coord_x, coord_y, output ready);
endinterface

interface pnos_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pnos_pkg::NOISE_W-1:0]  noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

// File: sv/perlin_noise_octave_sum_unit.sv
// perlin_noise_octave_sum_unit: top level, config registers, response register
// depends on pnos_pkg, pnos_if, pnos_tables, pnos_mul, pnos_core
//
//   channel   direction  handshake          payload
//   req_bus   in         valid/ready        kind, table_index, perm_value, grad, coord
//   rsp_bus   out        valid/ready        noise_value
//   csr_*     in         csr_we only        csr_index, csr_wdata
//
// ready stays high across a table write request
// an evaluate request runs octave_depth+1 octaves before its response; each
// octave runs 21 products and 4 gradient reads through the single shared multiplier
// ready is low from an evaluate until its response is loaded into the output register
// the output register holds while rsp_bus.ready is low; reset is synchronous, tables
// are not cleared
module perlin_noise_octave_sum_unit (
   input  logic                               clock,
   input  logic                               reset,
   pnos_req_if.sink                           req_bus,
   pnos_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [pnos_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pnos_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   logic [pnos_pkg::AMP_W-1:0]   amp_ff;
   logic [pnos_pkg::FREQ_W-1:0]  freq_ff;
   logic [pnos_pkg::DEPTH_W-1:0] depth_ff;
   logic                         rsp_valid_ff;
   logic [pnos_pkg::NOISE_W-1:0] noise_ff;

   pnos_pkg::cfg_type        cfg;
   pnos_pkg::tbl_wr_type     wr;
   pnos_pkg::tbl_rd_type     rd;
   pnos_pkg::core_stat_type  stat;

   logic                                  accept;
   logic                                  rsp_free;
   logic [pnos_pkg::PERM_W-1:0]           x_rdata, y_rdata;
   logic [pnos_pkg::GENTRY_W-1:0]         g_rdata;
   logic signed [pnos_pkg::MUL_A_W-1:0]   mul_a;
   logic signed [pnos_pkg::MUL_B_W-1:0]   mul_b;
   logic signed [pnos_pkg::PROD_W-1:0]    prod;

   assign accept        = req_bus.valid && stat.ready;
   assign req_bus.ready = stat.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.noise_value = noise_ff;

   always_comb begin
      cfg.amp   = amp_ff;
      cfg.freq  = freq_ff;
      cfg.depth = depth_ff;
      wr.we_x   = accept && (req_bus.kind == pnos_pkg::KIND_XPERM);
      wr.we_y   = accept && (req_bus.kind == pnos_pkg::KIND_YPERM);
      wr.we_g   = accept && (req_bus.kind == pnos_pkg::KIND_GRAD);
      wr.index  = req_bus.table_index;
      wr.perm   = req_bus.perm_value;
      wr.grad   = {req_bus.grad_y, req_bus.grad_x};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff   <= pnos_pkg::AMP_RESET;
         freq_ff  <= pnos_pkg::FREQ_RESET;
         depth_ff <= pnos_pkg::DEPTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pnos_pkg::CSR_AMP:   amp_ff   <= csr_wdata;
            pnos_pkg::CSR_FREQ:  freq_ff  <= csr_wdata;
            pnos_pkg::CSR_DEPTH: depth_ff <= csr_wdata[pnos_pkg::DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         noise_ff <= stat.sum;
      end
   end

   pnos_tables u_tables (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .x_rdata (x_rdata),
      .y_rdata (y_rdata),
      .g_rdata (g_rdata)
   );

   pnos_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   pnos_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .start    (accept && (req_bus.kind == pnos_pkg::KIND_EVAL)),
      .coord_x  (req_bus.coord_x),
      .coord_y  (req_bus.coord_y),
      .rsp_free (rsp_free),
      .x_rdata  (x_rdata),
      .y_rdata  (y_rdata),
      .g_rdata  (g_rdata),
      .prod     (prod),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .rd       (rd),
      .stat     (stat)
   );
endmodule

// File: sv/pnos_tables.sv
// pnos_tables: x/y permutation memories and gradient memory, registered reads
// depends on pnos_pkg
module pnos_tables (
   input  logic                              clock,
   input  pnos_pkg::tbl_wr_type              wr,
   input  pnos_pkg::tbl_rd_type              rd,
   output logic [pnos_pkg::PERM_W-1:0]       x_rdata,
   output logic [pnos_pkg::PERM_W-1:0]       y_rdata,
   output logic [pnos_pkg::GENTRY_W-1:0]     g_rdata
);
   logic [pnos_pkg::PERM_W-1:0]   x_mem [pnos_pkg::TABLE_SIZE];
   logic [pnos_pkg::PERM_W-1:0]   y_mem [pnos_pkg::TABLE_SIZE];
   logic [pnos_pkg::GENTRY_W-1:0] g_mem [pnos_pkg::TABLE_SIZE];

   always_ff @(posedge clock) begin
      if (wr.we_x) begin
         x_mem[wr.index] <= wr.perm;
      end
      x_rdata <= x_mem[rd.x_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.we_y) begin
         y_mem[wr.index] <= wr.perm;
      end
      y_rdata <= y_mem[rd.y_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.we_g) begin
         g_mem[wr.index] <= wr.grad;
      end
      g_rdata <= g_mem[rd.g_addr];
   end
endmodule

// File: sv/pnos_mul.sv
// pnos_mul: the shared signed multiplier with its product register
// depends on pnos_pkg
module pnos_mul (
   input  logic                                clock,
   input  logic signed [pnos_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [pnos_pkg::MUL_B_W-1:0] op_b,
   output logic signed [pnos_pkg::PROD_W-1:0]  prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end
endmodule

// File: sv/pnos_core.sv
// pnos_core: sequencer and datapath registers of one evaluate request
// depends on pnos_pkg; drives pnos_mul operands and pnos_tables read addresses
module pnos_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pnos_pkg::cfg_type                    cfg,
   input  logic                                 start,
   input  logic signed [pnos_pkg::COORD_W-1:0]  coord_x,
   input  logic signed [pnos_pkg::COORD_W-1:0]  coord_y,
   input  logic                                 rsp_free,
   input  logic [pnos_pkg::PERM_W-1:0]          x_rdata,
   input  logic [pnos_pkg::PERM_W-1:0]          y_rdata,
   input  logic [pnos_pkg::GENTRY_W-1:0]        g_rdata,
   input  logic signed [pnos_pkg::PROD_W-1:0]   prod,
   output logic signed [pnos_pkg::MUL_A_W-1:0]  mul_a,
   output logic signed [pnos_pkg::MUL_B_W-1:0]  mul_b,
   output pnos_pkg::tbl_rd_type                 rd,
   output pnos_pkg::core_stat_type              stat
);
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_MULX = 5'd1;
   localparam logic [4:0] ST_MULY = 5'd2;
   localparam logic [4:0] ST_SAVY = 5'd3;
   localparam logic [4:0] ST_FU0  = 5'd4;
   localparam logic [4:0] ST_FU1  = 5'd5;
   localparam logic [4:0] ST_FV0  = 5'd6;
   localparam logic [4:0] ST_FV1  = 5'd7;
   localparam logic [4:0] ST_FVS  = 5'd8;
   localparam logic [4:0] ST_CGR  = 5'd9;
   localparam logic [4:0] ST_CW   = 5'd10;
   localparam logic [4:0] ST_CDX  = 5'd11;
   localparam logic [4:0] ST_CDY  = 5'd12;
   localparam logic [4:0] ST_CDOT = 5'd13;
   localparam logic [4:0] ST_CMW  = 5'd14;
   localparam logic [4:0] ST_CACC = 5'd15;
   localparam logic [4:0] ST_ONRM = 5'd16;
   localparam logic [4:0] ST_OAMP = 5'd17;
   localparam logic [4:0] ST_OSUM = 5'd18;
   localparam logic [4:0] ST_DONE = 5'd19;

   localparam logic [16:0] ONE_Q16    = 17'h10000;
   localparam logic [17:0] THREE_Q16  = 18'h30000;
   localparam logic signed [53:0] R_BIAS = 54'sd1 <<< 46;

   logic [4:0] state_ff, state_in;

   logic signed [pnos_pkg::COORD_W-1:0] coord_x_ff, coord_y_ff;
   logic [31:0]  px_ff, py_ff;
   logic [pnos_pkg::PERM_W-1:0] px0_ff, px1_ff, py0_ff, py1_ff;
   logic [16:0]  uu_ff, vv_ff, w_ff;
   logic [1:0]   corner_ff;
   logic [pnos_pkg::GENTRY_W-1:0] g_ff;
   logic signed [33:0] t_ff, dot_ff;
   logic signed [53:0] r_ff;
   logic [21:0]  n_ff;
   logic [pnos_pkg::AMP_W-1:0]   amp_ff;
   logic [pnos_pkg::DEPTH_W-1:0] depth_ff, octave_ff;
   logic [pnos_pkg::NOISE_W-1:0] sum_ff;

   logic [15:0] u, v;
   logic [17:0] ku, kv;
   logic        ca, cb;
   logic [16:0] wa, wb;
   logic signed [16:0] dx, dy;
   logic signed [15:0] gx, gy;
   logic signed [53:0] rb;
   logic [30:0] sum_wide;

   assign u  = px_ff[23:8];
   assign v  = py_ff[23:8];
   assign ku = THREE_Q16 - {1'b0, u, 1'b0};
   assign kv = THREE_Q16 - {1'b0, v, 1'b0};
   assign ca = corner_ff[1];
   assign cb = corner_ff[0];
   assign wa = ca ? uu_ff : ONE_Q16 - uu_ff;
   assign wb = cb ? vv_ff : ONE_Q16 - vv_ff;
   // u - 1.0 in 17 bits is u with the top bit set
   assign dx = {ca, u};
   assign dy = {cb, v};
   assign gx = g_ff[15:0];
   assign gy = g_ff[31:16];
   assign rb = r_ff + R_BIAS;
   assign sum_wide = {6'd0, sum_ff} + {1'b0, prod[37:8]};

   always_comb begin
      rd.x_addr = (state_ff == ST_FU1) ? px_ff[31:24] + 8'd1 : px_ff[31:24];
      rd.y_addr = (state_ff == ST_FU1) ? py_ff[31:24] + 8'd1 : py_ff[31:24];
      rd.g_addr = (ca ? px1_ff : px0_ff) ^ (cb ? py1_ff : py0_ff);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MULX: begin
            mul_a = {{3{coord_x_ff[31]}}, coord_x_ff};
            mul_b = {3'd0, cfg.freq};
         end
         ST_MULY: begin
            mul_a = {{3{coord_y_ff[31]}}, coord_y_ff};
            mul_b = {3'd0, cfg.freq};
         end
         ST_FU0: begin
            mul_a = {19'd0, u};
            mul_b = {3'd0, u};
         end
         ST_FU1: begin
            mul_a = {17'd0, ku};
            mul_b = {3'd0, prod[31:16]};
         end
         ST_FV0: begin
            mul_a = {19'd0, v};
            mul_b = {3'd0, v};
         end
         ST_FV1: begin
            mul_a = {17'd0, kv};
            mul_b = {3'd0, prod[31:16]};
         end
         ST_CW: begin
            mul_a = {18'd0, wa};
            mul_b = {2'd0, wb};
         end
         ST_CDX: begin
            mul_a = {{19{gx[15]}}, gx};
            mul_b = {{2{dx[16]}}, dx};
         end
         ST_CDY: begin
            mul_a = {{19{gy[15]}}, gy};
            mul_b = {{2{dy[16]}}, dy};
         end
         ST_CMW: begin
            mul_a = {dot_ff[33], dot_ff};
            mul_b = {2'd0, w_ff};
         end
         ST_OAMP: begin
            mul_a = {13'd0, n_ff};
            mul_b = {3'd0, amp_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_MULX;
         ST_MULX: state_in = ST_MULY;
         ST_MULY: state_in = ST_SAVY;
         ST_SAVY: state_in = ST_FU0;
         ST_FU0:  state_in = ST_FU1;
         ST_FU1:  state_in = ST_FV0;
         ST_FV0:  state_in = ST_FV1;
         ST_FV1:  state_in = ST_FVS;
         ST_FVS:  state_in = ST_CGR;
         ST_CGR:  state_in = ST_CW;
         ST_CW:   state_in = ST_CDX;
         ST_CDX:  state_in = ST_CDY;
         ST_CDY:  state_in = ST_CDOT;
         ST_CDOT: state_in = ST_CMW;
         ST_CMW:  state_in = ST_CACC;
         ST_CACC: state_in = (corner_ff == 2'd3) ? ST_ONRM : ST_CGR;
         ST_ONRM: state_in = ST_OAMP;
         ST_OAMP: state_in = ST_OSUM;
         ST_OSUM: state_in = (octave_ff == depth_ff) ? ST_DONE : ST_FU0;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               coord_x_ff <= coord_x;
               coord_y_ff <= coord_y;
               amp_ff     <= cfg.amp;
               depth_ff   <= cfg.depth;
               octave_ff  <= '0;
               sum_ff     <= '0;
               r_ff       <= '0;
            end
         end
         ST_MULY: px_ff <= prod[31:0];
         ST_SAVY: py_ff <= prod[31:0];
         ST_FU1: begin
            px0_ff <= x_rdata;
            py0_ff <= y_rdata;
         end
         ST_FV0: begin
            uu_ff  <= prod[32:16];
            px1_ff <= x_rdata;
            py1_ff <= y_rdata;
         end
         ST_FVS: begin
            vv_ff     <= prod[32:16];
            corner_ff <= 2'd0;
         end
         ST_CW:   g_ff   <= g_rdata;
         ST_CDX:  w_ff   <= prod[32:16];
         ST_CDY:  t_ff   <= prod[33:0];
         ST_CDOT: dot_ff <= t_ff + prod[33:0];
         ST_CACC: begin
            r_ff      <= r_ff + prod;
            corner_ff <= corner_ff + 2'd1;
         end
         ST_ONRM: begin
            // blend mapped to (1+r)/2, negative or zero gives zero
            if (rb[53] || rb == '0) begin
               n_ff <= '0;
            end else begin
               n_ff <= rb[52:31];
            end
         end
         ST_OSUM: begin
            if (sum_wide > {6'd0, pnos_pkg::SAT_MAX}) begin
               sum_ff <= pnos_pkg::SAT_MAX;
            end else begin
               sum_ff <= sum_wide[24:0];
            end
            // next octave: double the scaled point, halve the amplitude
            px_ff     <= {px_ff[30:0], 1'b0};
            py_ff     <= {py_ff[30:0], 1'b0};
            amp_ff    <= {1'b0, amp_ff[15:1]};
            octave_ff <= octave_ff + 4'd1;
            r_ff      <= '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat.ready = (state_ff == ST_IDLE);
      stat.done  = (state_ff == ST_DONE) && rsp_free;
      stat.sum   = sum_ff;
   end
endmodule

// File: sv/pnos_chk.sv
// pnos_chk: port-level checks of the noise unit, bound to the top level
// depends on pnos_pkg and perlin_noise_octave_sum_unit
module pnos_chk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [pnos_pkg::KIND_W-1:0]        req_kind,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [pnos_pkg::NOISE_W-1:0]       rsp_noise_value
);
   // an evaluate request blocks further requests
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == pnos_pkg::KIND_EVAL |=> !req_ready)
      else $error("ready after evaluate request");

   // table writes keep ready high
   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind != pnos_pkg::KIND_EVAL |=> req_ready)
      else $error("ready dropped after table write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_noise_value))
      else $error("response changed while stalled");
endmodule

bind perlin_noise_octave_sum_unit pnos_chk u_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_kind        (req_bus.kind),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_noise_value (rsp_bus.noise_value)
);

// File: verif/tb_top.sv
// tb_top: self-checking bench for perlin_noise_octave_sum_unit
// depends on pnos_pkg, pnos_if and the unit; fills the tables, then runs directed,
// config sweep, random and backpressure tests against an in-bench noise predictor
module tb_top;
   import pnos_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   // perm values stay below this, so only that many gradient entries are ever read
   localparam int PERM_SPAN   = 32;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pnos_req_if req_if ();
   pnos_rsp_if rsp_if ();

   perlin_noise_octave_sum_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if.sink),
      .rsp_bus   (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [PERM_W-1:0]   x_perm [TABLE_SIZE];
   logic [PERM_W-1:0]   y_perm [TABLE_SIZE];
   logic [GENTRY_W-1:0] grad_tab [TABLE_SIZE];
   logic [AMP_W-1:0]    amp_q8;
   logic [FREQ_W-1:0]   freq_q8;
   logic [DEPTH_W-1:0]  depth;

   logic [NOISE_W-1:0] noise_expected [$];

   int  mismatch_count;
   int  fail_count;
   int  cycle_count;
   int  rsp_hold_cycles;
   bit  no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint fade(longint t);
      longint sq;
      longint k;
      sq = (t * t) >>> 16;
      k  = (64'sd3 <<< 16) - 2 * t;
      return (sq * k) >>> 16;
   endfunction

   function automatic longint octave_noise(logic signed [COORD_W-1:0] cx,
                                           logic signed [COORD_W-1:0] cy,
                                           longint freq);
      longint     px_l, py_l;
      logic [63:0] sx, sy;
      longint     u, v, uu, vv, wa, wb, dx, dy, dot, w, r;
      logic [IDX_W-1:0] ci, cj, pa, pb, gi;
      logic [GENTRY_W-1:0] g;
      longint gx, gy;
      px_l = longint'(cx) * freq;
      py_l = longint'(cy) * freq;
      sx = px_l;
      sy = py_l;
      sx = sx >> 8;
      sy = sy >> 8;
      u  = longint'(sx[15:0]);
      v  = longint'(sy[15:0]);
      ci = sx[23:16];
      cj = sy[23:16];
      uu = fade(u);
      vv = fade(v);
      r  = 0;
      for (int a = 0; a < 2; a++) begin
         wa = a ? uu : 65536 - uu;
         dx = a ? u - 65536 : u;
         pa = x_perm[IDX_W'(ci + a)];
         for (int b = 0; b < 2; b++) begin
            wb = b ? vv : 65536 - vv;
            dy = b ? v - 65536 : v;
            pb = y_perm[IDX_W'(cj + b)];
            gi = pa ^ pb;
            g  = grad_tab[gi];
            gx = longint'($signed(g[15:0]));
            gy = longint'($signed(g[31:16]));
            dot = gx * dx + gy * dy;
            w   = (wa * wb) >>> 16;
            r   = r + dot * w;
         end
      end
      r = r + (64'sd1 <<< 46);
      if (r <= 0)
         return 0;
      return r >>> 31;
   endfunction

   function automatic logic [NOISE_W-1:0] noise_sum(logic signed [COORD_W-1:0] cx,
                                                    logic signed [COORD_W-1:0] cy);
      longint sum;
      longint n;
      sum = 0;
      for (int k = 0; k <= depth; k++) begin
         n   = octave_noise(cx, cy, longint'(freq_q8) <<< k);
         sum = sum + ((n * longint'(amp_q8 >> k)) >>> 8);
         if (sum > longint'(SAT_MAX))
            sum = longint'(SAT_MAX);
      end
      return NOISE_W'(sum);
   endfunction

   function automatic int rand_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one request, update the predictor at the handshake
   task automatic send_req(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                           logic [PERM_W-1:0] perm, logic [GRAD_W-1:0] gx,
                           logic [GRAD_W-1:0] gy, logic [COORD_W-1:0] cx,
                           logic [COORD_W-1:0] cy);
      int gap;
      gap = rand_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.table_index <= idx;
      req_if.perm_value  <= perm;
      req_if.grad_x      <= gx;
      req_if.grad_y      <= gy;
      req_if.coord_x     <= cx;
      req_if.coord_y     <= cy;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      case (kind)
         KIND_XPERM: x_perm[idx] = perm;
         KIND_YPERM: y_perm[idx] = perm;
         KIND_GRAD:  grad_tab[idx] = {gy, gx};
         default:    noise_expected.push_back(noise_sum(cx, cy));
      endcase
   endtask

   task automatic send_eval(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
      send_req(KIND_EVAL, IDX_W'($urandom), PERM_W'($urandom), GRAD_W'($urandom),
               GRAD_W'($urandom), cx, cy);
   endtask

   function automatic logic [GRAD_W-1:0] rand_grad();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return GRAD_W'($urandom);
      if (r == 1)
         return 16'sd16384;
      if (r == 2)
         return -16'sd16384;
      return GRAD_W'($urandom_range(0, 32768) - 16384);
   endfunction

   task automatic send_rand_write();
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  idx;
      kind = KIND_W'($urandom_range(0, 2));
      if (kind == KIND_GRAD)
         idx = IDX_W'($urandom_range(0, PERM_SPAN - 1));
      else
         idx = IDX_W'($urandom);
      send_req(kind, idx, PERM_W'($urandom_range(0, PERM_SPAN - 1)), rand_grad(),
               rand_grad(), COORD_W'($urandom), COORD_W'($urandom));
   endtask

   // wait until all responses are in and the unit has settled, then write a register
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AMP:   amp_q8 = data;
         CSR_FREQ:  freq_q8 = data;
         CSR_DEPTH: depth = DEPTH_W'(data);
         default: ;
      endcase
   endtask

   task automatic set_config(logic [AMP_W-1:0] a, logic [FREQ_W-1:0] f,
                             logic [DEPTH_W-1:0] d);
      write_csr(CSR_AMP, a);
      write_csr(CSR_FREQ, f);
      write_csr(CSR_DEPTH, CSR_DATA_W'(d));
   endtask

   task automatic test_fill_tables();
      no_idle = 1'b1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         send_req(KIND_XPERM, IDX_W'(i), PERM_W'($urandom_range(0, PERM_SPAN - 1)),
                  '0, '0, '0, '0);
         send_req(KIND_YPERM, IDX_W'(i), PERM_W'($urandom_range(0, PERM_SPAN - 1)),
                  '0, '0, '0, '0);
      end
      for (int i = 0; i < PERM_SPAN; i++) begin
         send_req(KIND_GRAD, IDX_W'(i), '0, rand_grad(), rand_grad(), '0, '0);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_directed();
      // extreme gradients and permutations at the edges of the tables
      send_req(KIND_XPERM, 8'd255, PERM_W'(PERM_SPAN - 1), '0, '0, '0, '0);
      send_req(KIND_YPERM, 8'd0, 8'd0, '0, '0, '0, '0);
      send_req(KIND_GRAD, IDX_W'(PERM_SPAN - 1), '0, 16'sd16384, -16'sd16384, '0, '0);
      send_req(KIND_GRAD, 8'd0, '0, 16'h7FFF, 16'h8000, '0, '0);
      send_eval(32'h0000_0000, 32'h0000_0000);
      send_eval(32'h7FFF_FFFF, 32'h8000_0000);
      send_eval(32'h8000_0000, 32'h7FFF_FFFF);
      send_eval(32'hFFFF_FFFF, 32'h0000_FFFF);
      send_eval(32'h0000_8000, 32'hFFFF_8000);
      set_config(16'hFFFF, 16'hFFFF, 4'd15);
      send_eval(32'h0001_0000, 32'h0000_4000);
      send_eval(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      set_config(16'hFFFF, 16'd0, 4'd15);
      send_eval(32'h1234_5678, 32'h8765_4321);
      set_config(16'd0, 16'd1, 4'd3);
      send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      set_config(16'd256, 16'd256, 4'd0);
   endtask

   task automatic test_config_sweep();
      for (int p = 0; p < 4; p++) begin
         set_config(AMP_W'($urandom), FREQ_W'($urandom), DEPTH_W'($urandom_range(0, 4)));
         repeat (8) send_eval(COORD_W'($urandom), COORD_W'($urandom));
      end
   endtask

   task automatic test_random();
      for (int p = 0; p < 5; p++) begin
         if (p == 2)
            set_config(AMP_W'($urandom), FREQ_W'($urandom), 4'd15);
         else
            set_config(AMP_W'($urandom), FREQ_W'($urandom), DEPTH_W'($urandom_range(0, 2)));
         no_idle = (p == 3);
         for (int i = 0; i < (p == 2 ? 6 : 12); i++) begin
            if ($urandom_range(0, 1))
               send_eval(COORD_W'($urandom), COORD_W'($urandom));
            else
               send_rand_write();
         end
         no_idle = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      set_config(16'd200, 16'd300, 4'd0);
      rsp_hold_cycles = 400;
      no_idle = 1'b1;
      repeat (10) begin
         send_eval(COORD_W'($urandom), COORD_W'($urandom));
         send_rand_write();
      end
      no_idle = 1'b0;
   endtask

   // response checker
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (noise_expected.size() == 0) begin
               fail_count++;
               if (mismatch_count < 10)
                  $display("unexpected response noise_value=%h", rsp_if.noise_value);
               mismatch_count++;
            end else if (rsp_if.noise_value !== noise_expected[0]) begin
               fail_count++;
               if (mismatch_count < 10)
                  $display("noise_value mismatch: expected %h actual %h",
                           noise_expected[0], rsp_if.noise_value);
               mismatch_count++;
               void'(noise_expected.pop_front());
            end else begin
               void'(noise_expected.pop_front());
            end
         end
      end
   end

   // receiver stalls, the long hold is counted here
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) < 70) ||
                            ($urandom_range(0, 99) < 50 && rsp_if.ready);
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      mismatch_count  = 0;
      fail_count      = 0;
      rsp_hold_cycles = 0;
      no_idle         = 1'b0;
      amp_q8  = AMP_RESET;
      freq_q8 = FREQ_RESET;
      depth   = DEPTH_RESET;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_if.valid <= 1'b0;
      req_if.kind  <= '0;
      req_if.table_index <= '0;
      req_if.perm_value  <= '0;
      req_if.grad_x  <= '0;
      req_if.grad_y  <= '0;
      req_if.coord_x <= '0;
      req_if.coord_y <= '0;
      rsp_if.ready   <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_tables();
      test_directed();
      test_config_sweep();
      test_random();
      test_backpressure();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
      if (fail_count == 0 && noise_expected.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
